// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define BXS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define BXS_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define BXS_ASSERT(lbl, clk, rst_n, prop)
`define BXS_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== hdl/bxs_pkg.sv =====
package bxs_pkg;

  // xorshift64* output multiplier
  localparam logic [63:0] MULT_CONST = 64'h2545_F491_4F6C_DD1D;

  // request opcodes
  localparam logic [1:0] OP_INT   = 2'd0;
  localparam logic [1:0] OP_DBL   = 2'd1;
  localparam logic [1:0] OP_BYTES = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = 1'b1;

  localparam int unsigned DEF_MAX_BYTES = 64;

  // biased exponent of 2^-1: msb at bit 52 of the mantissa field
  localparam logic [10:0] EXP_TOP = 11'd1022;

  typedef struct packed {
    logic [63:0] value;
    logic        sampled;
    logic        last;
  } out_item_t;

  // one xorshift state update
  function automatic logic [63:0] xorshift_step(input logic [63:0] x);
    logic [63:0] t;
    t = x ^ (x >> 12);
    t = t ^ (t << 25);
    t = t ^ (t >> 27);
    return t;
  endfunction

endpackage

// ===== hdl/bxs_in_if.sv =====
interface bxs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] original;
  logic [6:0]  byte_count;

  modport source (output valid, opcode, original, byte_count, input ready);
  modport sink (input valid, opcode, original, byte_count, output ready);
endinterface

// ===== hdl/bxs_out_if.sv =====
interface bxs_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        sampled;
  logic        last;

  modport source (output valid, value, sampled, last, input ready);
  modport sink (input valid, value, sampled, last, output ready);
endinterface

// ===== hdl/bxs_mul.sv =====
module bxs_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  output logic        done,
  output logic [63:0] p
);
  import bxs_pkg::*;

  logic [63:0] x_r;
  logic [63:0] prod_r;
  logic [63:0] acc_r;
  logic [1:0]  ph_r;
  logic        busy_r;
  logic        done_r;
  logic [31:0] opa;
  logic [31:0] opb;

  // pick the partial product for this phase: lo*lo, hi*lo, lo*hi
  always_comb begin
    unique case (ph_r)
      2'd1:    begin opa = x_r[63:32]; opb = MULT_CONST[31:0];  end
      2'd2:    begin opa = x_r[31:0];  opb = MULT_CONST[63:32]; end
      default: begin opa = x_r[31:0];  opb = MULT_CONST[31:0];  end
    endcase
  end

  // multiply one phase, fold the previous partial product into the sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= 2'd0;
      end else if (busy_r) begin
        ph_r <= ph_r + 2'd1;
        if (ph_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= a;
    end
    prod_r <= opa * opb;
    if (busy_r) begin
      if (ph_r == 2'd1) begin
        acc_r <= prod_r;
      end else if (ph_r != 2'd0) begin
        acc_r <= acc_r + {prod_r[31:0], 32'd0};
      end
    end
  end

  assign done = done_r;
  assign p    = acc_r;
endmodule

// ===== hdl/bxs_norm.sv =====
module bxs_norm (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [52:0] m,
  output logic        done,
  output logic [63:0] bits
);
  import bxs_pkg::*;

  logic [52:0] w_r;
  logic [5:0]  lz_r;
  logic [2:0]  step_r;
  logic        busy_r;
  logic        done_r;
  logic        zero_r;
  logic        hit;
  logic [52:0] shifted;
  logic [5:0]  amt;

  // binary search for the leading one: 32, 16, 8, 4, 2, 1
  always_comb begin
    unique case (step_r)
      3'd0: begin
        hit = (w_r[52:21] == '0); shifted = {w_r[20:0], 32'd0}; amt = 6'd32;
      end
      3'd1: begin
        hit = (w_r[52:37] == '0); shifted = {w_r[36:0], 16'd0}; amt = 6'd16;
      end
      3'd2: begin
        hit = (w_r[52:45] == '0); shifted = {w_r[44:0], 8'd0};  amt = 6'd8;
      end
      3'd3: begin
        hit = (w_r[52:49] == '0); shifted = {w_r[48:0], 4'd0};  amt = 6'd4;
      end
      3'd4: begin
        hit = (w_r[52:51] == '0); shifted = {w_r[50:0], 2'd0};  amt = 6'd2;
      end
      3'd5: begin
        hit = !w_r[52];           shifted = {w_r[51:0], 1'b0};  amt = 6'd1;
      end
      default: begin
        hit = 1'b0;               shifted = w_r;                amt = 6'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 3'd0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift the mantissa up and count the zeros skipped
  always_ff @(posedge clk) begin
    if (start) begin
      w_r    <= m;
      lz_r   <= 6'd0;
      zero_r <= (m == '0);
    end else if (busy_r && hit) begin
      w_r  <= shifted;
      lz_r <= lz_r + amt;
    end
  end

  // pack sign, exponent and fraction; zero stays +0.0
  assign bits = zero_r ? 64'd0 : {1'b0, EXP_TOP - {5'd0, lz_r}, w_r[51:0]};
  assign done = done_r;
endmodule

// ===== hdl/budgeted_xorshift_sampler.sv =====
// Budgeted xorshift64* sampler.
// in_ch carries one request per item (opcode, original, byte_count); out_ch
// returns result items (value, sampled, last). Both use valid/ready and an
// item moves on a clock edge where both are high.
// cfg_we/cfg_index/cfg_wdata write the seed (index 0) or the budget (index 1)
// and load the generator state or remaining budget directly; write only idle.
// One request is handled at a time: in_ch.ready is high only while idle, and
// out_ch is a single output register held until the receiver takes it.
// A pass-through result reaches out_ch.valid in the cycle after accept; an
// integer sample goes through the step and multiply states, and a double
// also through the normalize state, before the output state. A request
// with no result leaves the block idle and ready.
// A byte run returns to the step and multiply states for each further byte
// once the previous one is taken.
// The sample paths use the 4-phase 32x32 multiplier, and the double path
// adds the 6-step leading-one search. A stalled receiver holds the
// block in its output state, with the result and generator state frozen.
// Reset (synchronous, rst_n low) clears the seed state to zero and the
// budget to unlimited, and returns the sequencer to idle.
`include "assert_macros.svh"

module budgeted_xorshift_sampler #(
  parameter int unsigned MAX_BYTES = bxs_pkg::DEF_MAX_BYTES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bxs_in_if.sink                         in_ch,
  bxs_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [bxs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_wdata
);
  import bxs_pkg::*;

  localparam int unsigned CW = $clog2(MAX_BYTES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STEP = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_NORM = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]    state_r,  state_nxt;
  logic [1:0]    op_r,     op_nxt;
  logic [CW-1:0] cnt_r,    cnt_nxt;
  logic [63:0]   gen_r,    gen_nxt;
  logic [31:0]   budget_r, budget_nxt;
  out_item_t     out_r,    out_nxt;

  logic          avail;
  logic [CW-1:0] sat_cnt;
  logic [63:0]   step_x;
  logic          mul_start;
  logic          mul_done;
  logic [63:0]   mul_p;
  logic          norm_start;
  logic          norm_done;
  logic [63:0]   norm_bits;

  assign step_x  = xorshift_step(gen_r);
  assign avail   = budget_r[31] || (budget_r != 32'd0);
  assign sat_cnt = (in_ch.byte_count > 7'(MAX_BYTES)) ? CW'(MAX_BYTES)
                                                      : CW'(in_ch.byte_count);

  bxs_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (step_x),
    .done  (mul_done),
    .p     (mul_p)
  );

  bxs_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .m     (mul_p[63:11]),
    .done  (norm_done),
    .bits  (norm_bits)
  );

  // sequence one request through step, multiply, normalize and output
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    cnt_nxt    = cnt_r;
    gen_nxt    = gen_r;
    budget_nxt = budget_r;
    out_nxt    = out_r;
    mul_start  = 1'b0;
    norm_start = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.opcode != OP_NONE) begin
          op_nxt  = in_ch.opcode;
          cnt_nxt = sat_cnt;
          if (!avail) begin
            // no budget left: pass the original back, drop byte runs
            if (in_ch.opcode != OP_BYTES) begin
              out_nxt.value   = (in_ch.opcode == OP_INT)
                                ? {32'd0, in_ch.original[31:0]} : in_ch.original;
              out_nxt.sampled = 1'b0;
              out_nxt.last    = 1'b1;
              state_nxt       = S_OUT;
            end
          end else begin
            if (!budget_r[31]) begin
              budget_nxt = budget_r - 32'd1;
            end
            if (in_ch.opcode != OP_BYTES || sat_cnt != '0) begin
              state_nxt = S_STEP;
            end
          end
        end
      end
      S_STEP: begin
        gen_nxt   = step_x;
        mul_start = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (mul_done) begin
          out_nxt.sampled = 1'b1;
          unique case (op_r)
            OP_INT: begin
              out_nxt.value = {32'd0, mul_p[63:32]};
              out_nxt.last  = 1'b1;
              state_nxt     = S_OUT;
            end
            OP_DBL: begin
              norm_start = 1'b1;
              state_nxt  = S_NORM;
            end
            default: begin
              out_nxt.value = {56'd0, mul_p[7:0]};
              out_nxt.last  = (cnt_r == CW'(1));
              state_nxt     = S_OUT;
            end
          endcase
        end
      end
      S_NORM: begin
        if (norm_done) begin
          out_nxt.value = norm_bits;
          out_nxt.last  = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          if (op_r == OP_BYTES && !out_r.last) begin
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = S_STEP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // load seed or budget on a configuration write
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEED:   gen_nxt    = cfg_wdata;
        CFG_BUDGET: budget_nxt = cfg_wdata[31:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      gen_r    <= 64'd0;
      budget_r <= 32'hFFFF_FFFF;
    end else begin
      state_r  <= state_nxt;
      gen_r    <= gen_nxt;
      budget_r <= budget_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    out_r <= out_nxt;
  end

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = (state_r == S_OUT);
  assign out_ch.value   = out_r.value;
  assign out_ch.sampled = out_r.sampled;
  assign out_ch.last    = out_r.last;

  `BXS_NEVER(a_in_out_excl, clk, rst_n, in_ch.ready && out_ch.valid)
  `BXS_ASSERT(a_mul_done_state, clk, rst_n, mul_done |-> state_r == S_MUL)
  `BXS_ASSERT(a_unlimited_holds, clk, rst_n, (budget_r[31] && !cfg_we) |=> budget_r[31])
  `BXS_ASSERT(a_byte_last, clk, rst_n, (out_ch.valid && op_r == OP_BYTES && out_r.last) |-> cnt_r == CW'(1))

endmodule
